### hw/rtl/ipd_frp_pkg.sv
// ----------------------------------------------------------------------------
// ipd_frp_pkg
// Shared constants and character tables for the +IPD frame request parser.
// ----------------------------------------------------------------------------
package ipd_frp_pkg;

  localparam int PATH_DEPTH_DEF  = 64;
  localparam int FIELD_CHARS_DEF = 7;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_P     = 8'h50;

  localparam logic [2:0] PREFIX_LEN = 3'd5;
  localparam logic [2:0] GET_LEN    = 3'd4;
  localparam logic [2:0] POST_LEN   = 3'd5;

  localparam logic METHOD_GET  = 1'b0;
  localparam logic METHOD_POST = 1'b1;

  // "+IPD,"
  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h2B;
      3'd1:    ch = 8'h49;
      3'd2:    ch = 8'h50;
      3'd3:    ch = 8'h44;
      3'd4:    ch = 8'h2C;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // "GET " and "POST ", indexed from the second character
  function automatic logic [7:0] method_char(input logic kind, input logic [2:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    if (kind == METHOD_GET) begin
      case (idx)
        3'd1:    ch = 8'h45;
        3'd2:    ch = 8'h54;
        3'd3:    ch = 8'h20;
        default: ch = 8'h00;
      endcase
    end else begin
      case (idx)
        3'd1:    ch = 8'h4F;
        3'd2:    ch = 8'h53;
        3'd3:    ch = 8'h54;
        3'd4:    ch = 8'h20;
        default: ch = 8'h00;
      endcase
    end
    return ch;
  endfunction

endpackage

### hw/rtl/ipd_frame_request_parser_top.sv
// ----------------------------------------------------------------------------
// ipd_frame_request_parser_top
// Hunts +IPD frames in a byte stream, parses link id and length, and reports
// GET/POST request paths held in a path memory, one path byte per word.
// ----------------------------------------------------------------------------
// Throughput: one received byte per cycle while parsing.
// A reported request stalls the input while its path words are read out (plus any
// output stall): the path memory has one read port and a registered read.
// After the frame's last byte, the first path word goes to the read register, then out.
// Reset (rst, synchronous) clears the parser and report_enable; the path
// memory is not cleared, entries are always written before being read.
// ----------------------------------------------------------------------------
module ipd_frame_request_parser_top #(
  parameter int PATH_DEPTH  = ipd_frp_pkg::PATH_DEPTH_DEF,
  parameter int FIELD_CHARS = ipd_frp_pkg::FIELD_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] link_id,
  output logic       method,
  output logic [7:0] path_byte,
  output logic       last
);

  localparam int AW = $clog2(PATH_DEPTH);
  localparam int FW = $clog2(FIELD_CHARS + 1);
  localparam logic [AW-1:0] PATH_MAX = AW'(PATH_DEPTH - 1);
  localparam logic [FW-1:0] FIELD_MAX = FW'(FIELD_CHARS);

  typedef enum logic [1:0] {PH_PREFIX, PH_LINK, PH_LENGTH, PH_PAYLOAD} phase_t;
  typedef enum logic [1:0] {PS_METHOD, PS_PATH, PS_DONE, PS_FAIL} path_status_t;
  typedef enum logic {MODE_RUN, MODE_EMIT} mode_t;

  mode_t          mode;
  phase_t         phase, phase_next;
  path_status_t   status, status_next;
  logic           report_enable;
  logic [2:0]     prefix_matched, prefix_matched_next;
  logic [FW-1:0]  field_chars, field_chars_next;
  logic           digits_stopped, digits_stopped_next;
  logic [7:0]     link_value, link_value_next;
  logic [15:0]    length_value, length_value_next;
  logic [15:0]    payload_count, payload_count_next;
  logic [2:0]     method_progress, method_progress_next;
  logic           method_kind, method_kind_next;
  logic [AW-1:0]  path_length, path_length_next;
  logic           start_emit;

  logic [AW-1:0]  emit_len;
  logic           emit_method;
  logic [AW-1:0]  rd_idx;
  logic           rd_pend;
  logic           rd_last;
  logic           rd_en;
  logic           load;
  logic           wr_en;
  logic [7:0]     mem_q;
  logic [7:0]     path_mem [PATH_DEPTH];

  logic           in_take;
  logic           is_digit;
  logic [3:0]     digit;
  logic [7:0]     link_calc;
  logic [15:0]    length_calc;
  logic           field_open;

  assign cfg_ready = 1'b1;
  assign in_stall  = (mode == MODE_EMIT);
  assign in_take   = in_valid && !in_stall;

  assign is_digit    = rx_byte inside {[ipd_frp_pkg::CH_ZERO : ipd_frp_pkg::CH_NINE]};
  assign digit       = 4'(rx_byte - ipd_frp_pkg::CH_ZERO);
  assign link_calc   = 8'((link_value << 3) + (link_value << 1) + {4'd0, digit});
  assign length_calc = 16'((length_value << 3) + (length_value << 1) + {12'd0, digit});
  assign field_open  = (field_chars < FIELD_MAX);

  // parser next state for one accepted byte
  always_comb begin
    phase_next           = phase;
    status_next          = status;
    prefix_matched_next  = prefix_matched;
    field_chars_next     = field_chars;
    digits_stopped_next  = digits_stopped;
    link_value_next      = link_value;
    length_value_next    = length_value;
    payload_count_next   = payload_count;
    method_progress_next = method_progress;
    method_kind_next     = method_kind;
    path_length_next     = path_length;
    wr_en                = 1'b0;
    start_emit           = 1'b0;

    case (phase)
      PH_PREFIX: begin
        if (rx_byte == ipd_frp_pkg::prefix_char(prefix_matched)) begin
          prefix_matched_next = prefix_matched + 3'd1;
          if (prefix_matched_next == ipd_frp_pkg::PREFIX_LEN) begin
            phase_next          = PH_LINK;
            prefix_matched_next = 3'd0;
            field_chars_next    = '0;
            digits_stopped_next = 1'b0;
            link_value_next     = 8'd0;
          end
        end else begin
          prefix_matched_next = (rx_byte == ipd_frp_pkg::CH_PLUS) ? 3'd1 : 3'd0;
        end
      end
      PH_LINK: begin
        if (rx_byte == ipd_frp_pkg::CH_COMMA) begin
          phase_next          = PH_LENGTH;
          field_chars_next    = '0;
          digits_stopped_next = 1'b0;
          length_value_next   = 16'd0;
        end else if (field_open) begin
          field_chars_next = field_chars + FW'(1);
          if (!digits_stopped) begin
            if (is_digit) link_value_next = link_calc;
            else digits_stopped_next = 1'b1;
          end
        end
      end
      PH_LENGTH: begin
        if (rx_byte == ipd_frp_pkg::CH_COLON) begin
          phase_next           = PH_PAYLOAD;
          payload_count_next   = 16'd0;
          method_progress_next = 3'd0;
          method_kind_next     = ipd_frp_pkg::METHOD_GET;
          status_next          = PS_METHOD;
          path_length_next     = '0;
        end else if (field_open) begin
          field_chars_next = field_chars + FW'(1);
          if (!digits_stopped) begin
            if (is_digit) length_value_next = length_calc;
            else digits_stopped_next = 1'b1;
          end
        end
      end
      default: begin
        case (status)
          PS_METHOD: begin
            if (method_progress == 3'd0) begin
              method_progress_next = 3'd1;
              if (rx_byte == ipd_frp_pkg::CH_G) method_kind_next = ipd_frp_pkg::METHOD_GET;
              else if (rx_byte == ipd_frp_pkg::CH_P) method_kind_next = ipd_frp_pkg::METHOD_POST;
              else begin
                status_next          = PS_FAIL;
                method_progress_next = 3'd0;
              end
            end else if (rx_byte != ipd_frp_pkg::method_char(method_kind, method_progress)) begin
              status_next = PS_FAIL;
            end else begin
              method_progress_next = method_progress + 3'd1;
              if ((method_kind == ipd_frp_pkg::METHOD_GET &&
                   method_progress_next == ipd_frp_pkg::GET_LEN) ||
                  (method_kind == ipd_frp_pkg::METHOD_POST &&
                   method_progress_next == ipd_frp_pkg::POST_LEN)) begin
                status_next = PS_PATH;
              end
            end
          end
          PS_PATH: begin
            if (rx_byte == ipd_frp_pkg::CH_SPACE) begin
              status_next = (path_length == '0) ? PS_FAIL : PS_DONE;
            end else if (rx_byte == ipd_frp_pkg::CH_NUL || path_length >= PATH_MAX) begin
              status_next = PS_FAIL;
            end else begin
              wr_en            = 1'b1;
              path_length_next = path_length + AW'(1);
            end
          end
          default: ;
        endcase

        payload_count_next = payload_count + 16'd1;
        if (payload_count_next >= length_value) begin
          phase_next          = PH_PREFIX;
          prefix_matched_next = 3'd0;
          start_emit          = report_enable && (status_next == PS_DONE);
          // ready for the next frame's payload
          payload_count_next   = 16'd0;
          method_progress_next = 3'd0;
          method_kind_next     = ipd_frp_pkg::METHOD_GET;
          status_next          = PS_METHOD;
          path_length_next     = '0;
        end
      end
    endcase
  end

  // emission: read ahead by one, hold the read while the output is stalled
  assign load  = rd_pend && (!out_valid || !out_stall);
  assign rd_en = (mode == MODE_EMIT) && (rd_idx != emit_len) && (!rd_pend || load);

  always_ff @(posedge clk) begin
    if (wr_en && in_take) begin
      path_mem[path_length] <= rx_byte;
    end
    if (rd_en) begin
      mem_q   <= path_mem[rd_idx];
      rd_last <= (rd_idx == emit_len - AW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_RUN;
      phase           <= PH_PREFIX;
      status          <= PS_METHOD;
      report_enable   <= 1'b0;
      prefix_matched  <= 3'd0;
      field_chars     <= '0;
      digits_stopped  <= 1'b0;
      link_value      <= 8'd0;
      length_value    <= 16'd0;
      payload_count   <= 16'd0;
      method_progress <= 3'd0;
      method_kind     <= 1'b0;
      path_length     <= '0;
      rd_idx          <= '0;
      rd_pend         <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        report_enable <= cfg_data;
      end

      if (in_take) begin
        phase           <= phase_next;
        status          <= status_next;
        prefix_matched  <= prefix_matched_next;
        field_chars     <= field_chars_next;
        digits_stopped  <= digits_stopped_next;
        link_value      <= link_value_next;
        length_value    <= length_value_next;
        payload_count   <= payload_count_next;
        method_progress <= method_progress_next;
        method_kind     <= method_kind_next;
        path_length     <= path_length_next;
        if (start_emit) begin
          mode        <= MODE_EMIT;
          emit_len    <= path_length;
          emit_method <= method_kind;
          rd_idx      <= '0;
        end
      end

      if (mode == MODE_EMIT) begin
        if (rd_en) rd_idx <= rd_idx + AW'(1);
        if (rd_en) rd_pend <= 1'b1;
        else if (load) rd_pend <= 1'b0;
        if (rd_idx == emit_len && !rd_pend) mode <= MODE_RUN;
      end

      if (load) begin
        out_valid <= 1'b1;
        path_byte <= mem_q;
        last      <= rd_last;
        link_id   <= link_value;
        method    <= emit_method;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/ipd_frp_checker.sv
// ----------------------------------------------------------------------------
// ipd_frp_checker
// Port-level checks on the frame request parser, bound to the top level.
// ----------------------------------------------------------------------------
module ipd_frp_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] link_id,
  input logic       method,
  input logic [7:0] path_byte,
  input logic       last
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=>
      out_valid && $stable(path_byte) && $stable(last) && $stable(link_id) && $stable(method))
    else $error("output word changed while stalled");

  // path bytes are never nul
  a_no_nul: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> path_byte != 8'h00)
    else $error("nul path byte reported");

  // words of one request share link id and method
  a_same_req: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=>
      !out_valid || ($stable(link_id) && $stable(method)))
    else $error("link id or method changed inside a request");

  // input stall only starts after a frame byte was taken
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(in_valid && !in_stall))
    else $error("input stalled without a taken byte");

endmodule

bind ipd_frame_request_parser_top ipd_frp_checker u_ipd_frp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .link_id   (link_id),
  .method    (method),
  .path_byte (path_byte),
  .last      (last)
);
